// ===== src/arsc_pkg.sv =====
package arsc_pkg;

   localparam int DEF_MAX_RANGES = 32;
   localparam int ID_W           = 16;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BAD   = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // per-cell command, shared by every cell
   typedef enum logic [2:0] {
      M_HOLD,
      M_ADD_MRG,
      M_ADD_INS,
      M_REM_SPLIT,
      M_REM_TRIM,
      M_SHIFT
   } mode_type;

   typedef struct packed {
      mode_type          mode;
      logic [ID_W-1:0]   s;     // range start, or key on lookup
      logic [ID_W-1:0]   e;
   } ctrl_type;

   typedef struct packed {
      logic              valid;
      logic              del;   // marked for compaction
      logic              hd;    // head of an add merge
      logic [ID_W-1:0]   start;
      logic [ID_W-1:0]   stop;
   } cell_type;

   typedef struct packed {
      logic abs;      // overlaps or touches [s,e]
      logic below;    // lies wholly below s, not touching
      logic touch;    // touches s
      logic split;    // strictly contains [s,e]
      logic match;    // contains s
   } flag_type;

   localparam cell_type EMPTY_CELL = '{valid: 1'b0, del: 1'b0, hd: 1'b0,
                                       start: '0, stop: '0};
   localparam flag_type EDGE_FLAGS = '{abs: 1'b0, below: 1'b1, touch: 1'b0,
                                       split: 1'b0, match: 1'b0};

endpackage

// ===== src/arsc_req_if.sv =====
interface arsc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] range_start;
   logic [15:0] range_end;
   logic [15:0] key_id;

   modport source (output valid, output op, output range_start, output range_end,
                   output key_id, input ready);
   modport sink   (input valid, input op, input range_start, input range_end,
                   input key_id, output ready);
endinterface

// ===== src/arsc_rsp_if.sv =====
interface arsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        hit;
   logic [7:0]  position;
   logic [8:0]  range_count;

   modport source (output valid, output status, output hit, output position,
                   output range_count, input ready);
   modport sink   (input valid, input status, input hit, input position,
                   input range_count, output ready);
endinterface

// ===== src/attribute_id_range_set_core.sv =====
// attribute_id_range_set_core
// Keeps a sorted set of disjoint, non-adjacent ranges of 16-bit IDs in a row
// of MAX_RANGES cells, one range per cell, each cell talking to its neighbors.
// Request channel (req_ch): op = add / remove / lookup, with range_start,
// range_end (add, remove) or key_id (lookup). Response channel (rsp_ch): one
// transaction per request with status, hit, position and range_count.
// One request is worked on at a time; req_ch.ready is high only while idle.
// An insert, a split, a refused request or an unused op goes from evaluation
// straight to the response; a merge or trim first passes through a compaction
// state that drops the marked ranges from the row one at a time, and a lookup
// first scans the row cell by cell until it finds the match or runs out.
// A new request is taken only after the response has been taken.
// The response waits in its register; a stalled rsp_ch holds the block in
// its response state until the transaction is taken, then ready rises again.
// Reset (synchronous, active high) empties the set: all cells go invalid and
// the count is zero. No clearing pass is needed.
module attribute_id_range_set_core #(
   parameter int MAX_RANGES = arsc_pkg::DEF_MAX_RANGES
) (
   input  logic        clock,
   input  logic        reset,
   arsc_req_if.sink    req_ch,
   arsc_rsp_if.source  rsp_ch
);

   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int IW = $clog2(MAX_RANGES);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EVAL  = 5'b00010,
      S_SHIFT = 5'b00100,
      S_LOOK  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]     op_ff, op_in;
   logic [15:0]    s_ff, s_in, e_ff, e_in, key_ff, key_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [1:0]     status_ff, status_in;
   logic           hit_ff, hit_in;
   logic [7:0]     pos_ff, pos_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [MAX_RANGES-1:0] mv_ff, mv_in;

   arsc_pkg::ctrl_type ctrl;
   arsc_pkg::cell_type cells [MAX_RANGES];
   arsc_pkg::flag_type flags [MAX_RANGES];

   logic [MAX_RANGES-1:0] abs_v, before_v, touch_v, split_v, match_v, del_v;
   logic [MAX_RANGES-1:0] posv, pt, shr_v, shl_v;
   logic                  full;

   // ---- row of cells ----
   genvar g;
   generate
      for (g = 0; g < MAX_RANGES; g++) begin : g_cell
         arsc_pkg::cell_type lft_c, rgt_c;
         arsc_pkg::flag_type lft_f;
         if (g == 0) begin : g_first
            assign lft_c = arsc_pkg::EMPTY_CELL;
            assign lft_f = arsc_pkg::EDGE_FLAGS;
            assign posv[g] = !before_v[g];
         end else begin : g_mid
            assign lft_c = cells[g-1];
            assign lft_f = flags[g-1];
            assign posv[g] = !before_v[g] && before_v[g-1];
         end
         if (g == MAX_RANGES - 1) begin : g_last
            assign rgt_c = arsc_pkg::EMPTY_CELL;
         end else begin : g_inner
            assign rgt_c = cells[g+1];
         end

         arsc_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (ctrl),
            .shr     (shr_v[g]),
            .shl     (shl_v[g]),
            .lft     (lft_c),
            .lft_flg (lft_f),
            .rgt     (rgt_c),
            .cur     (cells[g]),
            .flg     (flags[g])
         );

         assign abs_v[g]    = flags[g].abs;
         assign before_v[g] = flags[g].below;
         assign touch_v[g]  = flags[g].touch;
         assign split_v[g]  = flags[g].split;
         assign match_v[g]  = flags[g].match;
         assign del_v[g]    = cells[g].del;
      end
   endgenerate

   // insert point: new entry on add, upper half on split
   assign pt    = (op_ff == arsc_pkg::OP_ADD) ? posv : (split_v << 1);
   // cells strictly above the insert point take their left neighbor
   assign shr_v = ~(pt ^ (pt - MAX_RANGES'(1)));
   // cells at or above the lowest marked cell take their right neighbor
   assign shl_v = ~((del_v - MAX_RANGES'(1)) & ~del_v);

   assign full = (count_ff == CW'(MAX_RANGES));

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      s_in      = s_ff;
      e_in      = e_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      status_in = status_ff;
      hit_in    = hit_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      mv_in     = mv_ff;
      ctrl.mode = arsc_pkg::M_HOLD;
      ctrl.s    = (op_ff == arsc_pkg::OP_LOOKUP) ? key_ff : s_ff;
      ctrl.e    = e_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.op;
               s_in     = req_ch.range_start;
               e_in     = req_ch.range_end;
               key_in   = req_ch.key_id;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            status_in = arsc_pkg::ST_OK;
            hit_in    = 1'b0;
            pos_in    = '0;
            state_in  = S_RESP;
            if (op_ff == arsc_pkg::OP_ADD || op_ff == arsc_pkg::OP_REMOVE) begin
               if (s_ff > e_ff) begin
                  status_in = arsc_pkg::ST_BAD;
               end else if (op_ff == arsc_pkg::OP_ADD) begin
                  if (full && !(|touch_v)) begin
                     status_in = arsc_pkg::ST_FULL;
                  end else if (|abs_v) begin
                     ctrl.mode = arsc_pkg::M_ADD_MRG;
                     state_in  = S_SHIFT;
                  end else begin
                     ctrl.mode = arsc_pkg::M_ADD_INS;
                     count_in  = count_ff + CW'(1);
                  end
               end else begin
                  if (|split_v) begin
                     if (full) begin
                        status_in = arsc_pkg::ST_FULL;
                     end else begin
                        ctrl.mode = arsc_pkg::M_REM_SPLIT;
                        count_in  = count_ff + CW'(1);
                     end
                  end else begin
                     ctrl.mode = arsc_pkg::M_REM_TRIM;
                     state_in  = S_SHIFT;
                  end
               end
            end else if (op_ff == arsc_pkg::OP_LOOKUP) begin
               mv_in    = match_v;
               idx_in   = '0;
               state_in = S_LOOK;
            end
         end
         S_SHIFT: begin
            // drop one marked cell per cycle
            if (|del_v) begin
               ctrl.mode = arsc_pkg::M_SHIFT;
               count_in  = count_ff - CW'(1);
            end else begin
               state_in = S_RESP;
            end
         end
         S_LOOK: begin
            if (mv_ff[0]) begin
               hit_in   = 1'b1;
               pos_in   = 8'(idx_ff);
               state_in = S_RESP;
            end else if (mv_ff == '0) begin
               state_in = S_RESP;
            end else begin
               mv_in  = mv_ff >> 1;
               idx_in = idx_ff + IW'(1);
            end
         end
         S_RESP: begin
            if (rsp_ch.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      s_ff      <= s_in;
      e_ff      <= e_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      hit_ff    <= hit_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      mv_ff     <= mv_in;
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = (state_ff == S_RESP);
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.hit         = hit_ff;
   assign rsp_ch.position    = pos_ff;
   assign rsp_ch.range_count = 9'(count_ff);

   // ---- checks ----
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RANGES))
      else $error("range count above capacity");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request taken while a response is pending");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && status_ff == arsc_pkg::ST_FULL) |-> full)
      else $error("full status with free entries");

   a_shift_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && (|del_v)) |=> count_ff == $past(count_ff) - CW'(1))
      else $error("compaction step did not drop one range");

endmodule

// ===== src/arsc_cell.sv =====
module arsc_cell (
   input  logic                clock,
   input  logic                reset,
   input  arsc_pkg::ctrl_type  ctrl,
   input  logic                shr,
   input  logic                shl,
   input  arsc_pkg::cell_type  lft,
   input  arsc_pkg::flag_type  lft_flg,
   input  arsc_pkg::cell_type  rgt,
   output arsc_pkg::cell_type  cur,
   output arsc_pkg::flag_type  flg
);

   arsc_pkg::cell_type cur_ff, cur_in;
   logic [16:0] s_w, e_w, st_w, sp_w, s1, e1, sp1;

   assign s_w  = {1'b0, ctrl.s};
   assign e_w  = {1'b0, ctrl.e};
   assign st_w = {1'b0, cur_ff.start};
   assign sp_w = {1'b0, cur_ff.stop};
   assign s1   = s_w + 17'd1;
   assign e1   = e_w + 17'd1;
   assign sp1  = sp_w + 17'd1;

   always_comb begin
      flg.abs    = cur_ff.valid && (sp1 >= s_w) && (st_w <= e1);
      flg.below  = cur_ff.valid && (sp1 < s_w);
      flg.touch  = cur_ff.valid && (s1 >= st_w) && (s_w <= sp1);
      flg.split  = cur_ff.valid && (st_w < s_w) && (sp_w > e_w);
      flg.match  = cur_ff.valid && (st_w <= s_w) && (s_w <= sp_w);
   end

   always_comb begin
      cur_in = cur_ff;
      case (ctrl.mode)
         arsc_pkg::M_ADD_MRG: begin
            cur_in.del = 1'b0;
            cur_in.hd  = 1'b0;
            if (flg.abs && !lft_flg.abs) begin
               cur_in.hd = 1'b1;
               if (ctrl.s < cur_ff.start) cur_in.start = ctrl.s;
               if (ctrl.e > cur_ff.stop) cur_in.stop = ctrl.e;
            end else if (flg.abs) begin
               cur_in.del = 1'b1;
            end
         end
         arsc_pkg::M_ADD_INS: begin
            if (shr) begin
               cur_in     = lft;
               cur_in.del = 1'b0;
               cur_in.hd  = 1'b0;
            end else if (!flg.below && lft_flg.below) begin
               cur_in = '{valid: 1'b1, del: 1'b0, hd: 1'b0,
                          start: ctrl.s, stop: ctrl.e};
            end
         end
         arsc_pkg::M_REM_SPLIT: begin
            if (flg.split) begin
               cur_in.stop = ctrl.s - 16'd1;
            end else if (lft_flg.split) begin
               cur_in = '{valid: 1'b1, del: 1'b0, hd: 1'b0,
                          start: ctrl.e + 16'd1, stop: lft.stop};
            end else if (shr) begin
               cur_in     = lft;
               cur_in.del = 1'b0;
               cur_in.hd  = 1'b0;
            end
         end
         arsc_pkg::M_REM_TRIM: begin
            cur_in.hd  = 1'b0;
            cur_in.del = cur_ff.valid && (cur_ff.start >= ctrl.s) && (cur_ff.stop <= ctrl.e);
            if (cur_ff.valid && cur_ff.start < ctrl.s && cur_ff.stop >= ctrl.s)
               cur_in.stop = ctrl.s - 16'd1;
            if (cur_ff.valid && cur_ff.start >= ctrl.s && cur_ff.start <= ctrl.e &&
                cur_ff.stop > ctrl.e)
               cur_in.start = ctrl.e + 16'd1;
         end
         arsc_pkg::M_SHIFT: begin
            if (shl) begin
               cur_in = rgt;
            end else if (cur_ff.hd && rgt.del && rgt.stop > cur_ff.stop) begin
               cur_in.stop = rgt.stop;
            end
         end
         default: cur_in = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.valid <= 1'b0;
         cur_ff.del   <= 1'b0;
         cur_ff.hd    <= 1'b0;
      end else begin
         cur_ff <= cur_in;
      end
   end

   assign cur = cur_ff;

endmodule
